### src/gps_pkg.sv
`timescale 1ns / 1ps

package gps_pkg;

  // Path storage.
  localparam int MAX_POINTS = 1024;
  localparam int MAX_DIMS   = 4;
  localparam int CAPACITY   = MAX_POINTS * MAX_DIMS;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int DIM_W      = $clog2(MAX_DIMS + 1);

  // Field and register widths.
  localparam int COORD_W   = 32;
  localparam int DIMS_W    = 3;
  localparam int WEIGHT_W  = 17;
  localparam int TOL_W     = 31;
  localparam int SWEEP_W   = 16;
  localparam int SUM_W     = 48;
  localparam int ACTION_W  = 2;

  // Arithmetic widths of the update step.
  localparam int FRAC_W  = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int LAP_W   = COORD_W + 3;
  localparam int PROD_W  = LAP_W + WEIGHT_W + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int STEP_W  = ACC_W - FRAC_W;
  localparam int UPD_W   = STEP_W + 1;
  localparam int DELTA_W = COORD_W + 1;

  // Stream and configuration port widths.
  localparam int TDATA_IN_W  = COORD_W;
  localparam int TUSER_IN_W  = ACTION_W;
  localparam int OUT_BITS    = COORD_W + 1 + SWEEP_W;
  localparam int TDATA_OUT_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = TDATA_OUT_W - OUT_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = TOL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMS          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DATA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SMOOTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS    = 3'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // One enable per step of the shared update unit.
  typedef struct packed {
    logic ops;
    logic mul_d;
    logic mul_s;
    logic acc;
    logic upd;
    logic dlt;
    logic sum;
    logic clr;
  } alu_ctrl_t;

endpackage

### src/gps_alu.sv
`timescale 1ns / 1ps

module gps_alu (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gps_pkg::alu_ctrl_t                   ctrl_i,
  input  logic        [gps_pkg::WEIGHT_W-1:0]  wd_i,
  input  logic        [gps_pkg::WEIGHT_W-1:0]  ws_i,
  input  logic signed [gps_pkg::COORD_W-1:0]   cur_i,
  input  logic signed [gps_pkg::COORD_W-1:0]   prev_i,
  input  logic signed [gps_pkg::COORD_W-1:0]   next_i,
  input  logic signed [gps_pkg::COORD_W-1:0]   orig_i,
  output logic        [gps_pkg::COORD_W-1:0]   nv_o,
  output logic        [gps_pkg::SUM_W-1:0]     sum_o
);
  import gps_pkg::*;

  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [LAP_W-1:0]    lap_q;
  logic signed [PROD_W-1:0]   pd_q;
  logic signed [PROD_W-1:0]   ps_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [COORD_W-1:0]  nv_q;
  logic        [DELTA_W-1:0]  delta_q;
  logic        [SUM_W-1:0]    sum_q;

  logic signed [WEIGHT_W:0]   mul_a;
  logic signed [LAP_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [STEP_W-1:0]   step;
  logic signed [UPD_W-1:0]    upd;
  logic        [UPD_W-COORD_W:0] upd_hi;
  logic signed [COORD_W-1:0]  nv_d;
  logic signed [DELTA_W-1:0]  dd;
  logic        [SUM_W:0]      sum_ext;

  // The single multiplier serves both weight products in turn.
  assign mul_a = ctrl_i.mul_d ? $signed({1'b0, wd_i}) : $signed({1'b0, ws_i});
  assign mul_b = ctrl_i.mul_d ? LAP_W'(diff_q) : lap_q;
  assign mul_p = mul_a * mul_b;

  assign step   = acc_q[ACC_W-1:FRAC_W];
  assign upd    = UPD_W'(cur_i) + UPD_W'(step);
  assign upd_hi = upd[UPD_W-1:COORD_W-1];

  always_comb begin
    if (&upd_hi || ~|upd_hi) begin
      nv_d = upd[COORD_W-1:0];
    end else if (upd[UPD_W-1]) begin
      nv_d = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      nv_d = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  assign dd      = DELTA_W'(nv_q) - DELTA_W'(cur_i);
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(delta_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ops) begin
      diff_q <= DIFF_W'(orig_i) - DIFF_W'(cur_i);
      lap_q  <= LAP_W'(prev_i) + LAP_W'(next_i) - (LAP_W'(cur_i) <<< 1);
    end
    if (ctrl_i.mul_d) begin
      pd_q <= mul_p;
    end
    if (ctrl_i.mul_s) begin
      ps_q <= mul_p;
    end
    if (ctrl_i.acc) begin
      acc_q <= ACC_W'(pd_q) + ACC_W'(ps_q) + ACC_W'(1 << (FRAC_W - 1));
    end
    if (ctrl_i.upd) begin
      nv_q <= nv_d;
    end
    if (ctrl_i.dlt) begin
      delta_q <= dd[DELTA_W-1] ? DELTA_W'(-dd) : DELTA_W'(dd);
    end
  end

  // Sum of changes over one sweep, saturating at its full scale.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.clr) begin
      sum_q <= '0;
    end else if (ctrl_i.sum) begin
      sum_q <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end
  end

  assign nv_o  = nv_q;
  assign sum_o = sum_q;

endmodule

### src/gradient_path_smoother_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Word contents (low bit up)
// s_axis    in         tvalid tready tdata[31:0] tuser[1:0] tdata: coord_in; tuser: action
// m_axis    out        tvalid tready tdata[55:0] tlast tuser tdata: coord_out, converged,
//                                                           sweeps_used, zero pad;
//                                                           tlast: last_coord; tuser: read_valid
// cfg       in         cfg_valid_i cfg_ready_o cfg_index_i  index 0..4, data in low bits
//                      cfg_data_i[30:0]
//
// A load word is taken and produces no result. A read word passes through the registered
// read port of the smoothed-path memory before its result is posted. A start word first
// copies the C loaded coordinates, then runs sweeps over the N points of D coordinates,
// then posts the status word: each interior point costs one range check, and each of
// its coordinates nine steps, two memory reads and seven through the one shared
// multiply/accumulate unit.
// Reset clears control state and sets the configuration registers to defaults; the path
// memories are not cleared and hold nothing meaningful until loaded. The input stalls
// (tready low) while a word is being worked on and while a result waits on a stalled output.

module gradient_path_smoother_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [gps_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // coord_in
  input  logic [gps_pkg::TUSER_IN_W-1:0]     s_axis_tuser,  // action

  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [gps_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // coord_out, converged, sweeps_used
  output logic                               m_axis_tlast,  // last_coord
  output logic                               m_axis_tuser,  // read_valid

  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import gps_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_READ  = 4'd1;
  localparam logic [ST_W-1:0] ST_COPY  = 4'd2;
  localparam logic [ST_W-1:0] ST_PT    = 4'd3;
  localparam logic [ST_W-1:0] ST_RD0   = 4'd4;
  localparam logic [ST_W-1:0] ST_RD1   = 4'd5;
  localparam logic [ST_W-1:0] ST_OPS   = 4'd6;
  localparam logic [ST_W-1:0] ST_MULD  = 4'd7;
  localparam logic [ST_W-1:0] ST_MULS  = 4'd8;
  localparam logic [ST_W-1:0] ST_ACC   = 4'd9;
  localparam logic [ST_W-1:0] ST_UPD   = 4'd10;
  localparam logic [ST_W-1:0] ST_DLT   = 4'd11;
  localparam logic [ST_W-1:0] ST_SUM   = 4'd12;
  localparam logic [ST_W-1:0] ST_SWEND = 4'd13;
  localparam logic [ST_W-1:0] ST_DONE  = 4'd14;

  // Configuration registers.
  logic [DIMS_W-1:0]   dims_q;
  logic [WEIGHT_W-1:0] wd_q;
  logic [WEIGHT_W-1:0] ws_q;
  logic [TOL_W-1:0]    tol_q;
  logic [SWEEP_W-1:0]  max_sw_q;

  // Sequencer state.
  logic [ST_W-1:0]    state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rp_q, rp_d;
  logic               fresh_q, fresh_d;
  logic [CNT_W-1:0]   pb_q, pb_d;
  logic [DIM_W-1:0]   j_q, j_d;
  logic [CNT_W-1:0]   c_q, c_d;
  logic               cpv_q, cpv_d;
  logic [ADDR_W-1:0]  cpa_q, cpa_d;
  logic [SWEEP_W-1:0] sweeps_q, sweeps_d;
  logic               conv_q, conv_d;
  logic               hit_q, hit_d;

  // Operand registers for the update unit.
  logic [COORD_W-1:0] cur_q, cur_d;
  logic [COORD_W-1:0] prev_q, prev_d;
  logic [COORD_W-1:0] orig_q, orig_d;

  // Output register.
  logic               m_valid_q;
  logic               m_load;
  logic [COORD_W-1:0] m_coord_q, m_coord_d;
  logic               m_conv_q, m_conv_d;
  logic [SWEEP_W-1:0] m_sweeps_q, m_sweeps_d;
  logic               m_last_q, m_last_d;
  logic               m_rv_q, m_rv_d;

  // Memories and their ports.
  logic [COORD_W-1:0] smooth_mem [CAPACITY];
  logic [COORD_W-1:0] orig_mem   [CAPACITY];
  logic [ADDR_W-1:0]  ra_addr, rb_addr, ro_addr, sm_wa, or_wa;
  logic [COORD_W-1:0] sm_wd;
  logic               sm_we, or_we;
  logic [COORD_W-1:0] rda_q, rdb_q, rdo_q;

  logic [DIM_W-1:0]   d_eff;
  logic [CNT_W-1:0]   k, kp, km;
  logic [CNT_W:0]     pt_end;
  logic [CNT_W-1:0]   ld_addr;
  logic [SWEEP_W:0]   sweeps_inc;
  logic               in_acc;
  logic               cfg_acc;

  alu_ctrl_t          ctrl;
  logic [COORD_W-1:0] nv;
  logic [SUM_W-1:0]   sum;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q   <= DIMS_W'(2);
      wd_q     <= WEIGHT_W'(45875);
      ws_q     <= WEIGHT_W'(19661);
      tol_q    <= TOL_W'(7);
      max_sw_q <= SWEEP_W'(4096);
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_DIMS:          dims_q   <= cfg_data_i[DIMS_W-1:0];
        CFG_WEIGHT_DATA:   wd_q     <= cfg_data_i[WEIGHT_W-1:0];
        CFG_WEIGHT_SMOOTH: ws_q     <= cfg_data_i[WEIGHT_W-1:0];
        CFG_TOLERANCE:     tol_q    <= cfg_data_i[TOL_W-1:0];
        CFG_MAX_SWEEPS:    max_sw_q <= cfg_data_i[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Coordinates per point, clamped to the supported range.
  always_comb begin
    if (dims_q == '0) begin
      d_eff = DIM_W'(1);
    end else if (int'(dims_q) > MAX_DIMS) begin
      d_eff = DIM_W'(MAX_DIMS);
    end else begin
      d_eff = DIM_W'(dims_q);
    end
  end

  // The coordinate being updated, and the same coordinate of its neighbors.
  assign k  = pb_q + CNT_W'(j_q);
  assign kp = k + CNT_W'(d_eff);
  assign km = k - CNT_W'(d_eff);

  // A point is interior while the point after it is complete.
  assign pt_end = {1'b0, pb_q} + (CNT_W+1)'({d_eff, 1'b0});

  assign ld_addr    = fresh_q ? '0 : count_q;
  assign sweeps_inc = {1'b0, sweeps_q} + (SWEEP_W+1)'(1);

  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rp_d     = rp_q;
    fresh_d  = fresh_q;
    pb_d     = pb_q;
    j_d      = j_q;
    c_d      = c_q;
    cpv_d    = 1'b0;
    cpa_d    = cpa_q;
    sweeps_d = sweeps_q;
    conv_d   = conv_q;
    hit_d    = hit_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    orig_d   = orig_q;

    m_load     = 1'b0;
    m_coord_d  = '0;
    m_conv_d   = 1'b0;
    m_sweeps_d = '0;
    m_last_d   = 1'b0;
    m_rv_d     = 1'b0;

    ctrl    = '0;
    ra_addr = rp_q[ADDR_W-1:0];
    rb_addr = km[ADDR_W-1:0];
    ro_addr = k[ADDR_W-1:0];
    or_we   = 1'b0;
    or_wa   = ld_addr[ADDR_W-1:0];
    sm_we   = 1'b0;
    sm_wa   = ld_addr[ADDR_W-1:0];
    sm_wd   = s_axis_tdata;

    // The copy pass writes each coordinate in the cycle after its read of the original path.
    if (cpv_q) begin
      sm_we = 1'b1;
      sm_wa = cpa_q;
      sm_wd = rdo_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_e'(s_axis_tuser))
            ACT_LOAD: begin
              fresh_d = 1'b0;
              if (fresh_q || (count_q < CNT_W'(CAPACITY))) begin
                or_we   = 1'b1;
                sm_we   = 1'b1;
                count_d = ld_addr + CNT_W'(1);
              end
            end
            ACT_START: begin
              c_d     = '0;
              state_d = ST_COPY;
            end
            ACT_READ: begin
              hit_d   = rp_q < count_q;
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        m_load = 1'b1;
        if (hit_q) begin
          m_coord_d = rda_q;
          m_last_d  = ({1'b0, rp_q} + (CNT_W+1)'(1)) == {1'b0, count_q};
          m_rv_d    = 1'b1;
          rp_d      = rp_q + CNT_W'(1);
        end
        state_d = ST_IDLE;
      end
      ST_COPY: begin
        ro_addr = c_q[ADDR_W-1:0];
        if (c_q < count_q) begin
          cpv_d = 1'b1;
          cpa_d = c_q[ADDR_W-1:0];
          c_d   = c_q + CNT_W'(1);
        end else begin
          pb_d     = CNT_W'(d_eff);
          sweeps_d = '0;
          ctrl.clr = 1'b1;
          state_d  = ST_PT;
        end
      end
      ST_PT: begin
        if (pt_end <= {1'b0, count_q}) begin
          j_d     = '0;
          state_d = ST_RD0;
        end else begin
          state_d = ST_SWEND;
        end
      end
      ST_RD0: begin
        ra_addr = k[ADDR_W-1:0];
        state_d = ST_RD1;
      end
      ST_RD1: begin
        cur_d   = rda_q;
        prev_d  = rdb_q;
        orig_d  = rdo_q;
        ra_addr = kp[ADDR_W-1:0];
        state_d = ST_OPS;
      end
      ST_OPS: begin
        ctrl.ops = 1'b1;
        state_d  = ST_MULD;
      end
      ST_MULD: begin
        ctrl.mul_d = 1'b1;
        state_d    = ST_MULS;
      end
      ST_MULS: begin
        ctrl.mul_s = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        ctrl.acc = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        ctrl.upd = 1'b1;
        state_d  = ST_DLT;
      end
      ST_DLT: begin
        ctrl.dlt = 1'b1;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        ctrl.sum = 1'b1;
        sm_we    = 1'b1;
        sm_wa    = k[ADDR_W-1:0];
        sm_wd    = nv;
        if (j_q + DIM_W'(1) == d_eff) begin
          pb_d    = pb_q + CNT_W'(d_eff);
          state_d = ST_PT;
        end else begin
          j_d     = j_q + DIM_W'(1);
          state_d = ST_RD0;
        end
      end
      ST_SWEND: begin
        sweeps_d = sweeps_inc[SWEEP_W-1:0];
        if (sum < SUM_W'(tol_q)) begin
          conv_d  = 1'b1;
          state_d = ST_DONE;
        end else if (sweeps_inc >= (SWEEP_W+1)'(max_sw_q)) begin
          conv_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          pb_d     = CNT_W'(d_eff);
          ctrl.clr = 1'b1;
          state_d  = ST_PT;
        end
      end
      ST_DONE: begin
        m_load     = 1'b1;
        m_conv_d   = conv_q;
        m_sweeps_d = sweeps_q;
        fresh_d    = 1'b1;
        rp_d       = '0;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rp_q      <= '0;
      fresh_q   <= 1'b1;
      pb_q      <= '0;
      j_q       <= '0;
      c_q       <= '0;
      cpv_q     <= 1'b0;
      sweeps_q  <= '0;
      conv_q    <= 1'b0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rp_q     <= rp_d;
      fresh_q  <= fresh_d;
      pb_q     <= pb_d;
      j_q      <= j_d;
      c_q      <= c_d;
      cpv_q    <= cpv_d;
      sweeps_q <= sweeps_d;
      conv_q   <= conv_d;
      hit_q    <= hit_d;
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cpa_q  <= cpa_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    orig_q <= orig_d;
    if (m_load) begin
      m_coord_q  <= m_coord_d;
      m_conv_q   <= m_conv_d;
      m_sweeps_q <= m_sweeps_d;
      m_last_q   <= m_last_d;
      m_rv_q     <= m_rv_d;
    end
  end

  // Smoothed path: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      smooth_mem[sm_wa] <= sm_wd;
    end
    rda_q <= smooth_mem[ra_addr];
    rdb_q <= smooth_mem[rb_addr];
  end

  // Original path: written by loads only.
  always_ff @(posedge clk_i) begin
    if (or_we) begin
      orig_mem[or_wa] <= s_axis_tdata;
    end
    rdo_q <= orig_mem[ro_addr];
  end

  gps_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .wd_i   (wd_q),
    .ws_i   (ws_q),
    .cur_i  (cur_q),
    .prev_i (prev_q),
    .next_i (rda_q),
    .orig_i (orig_q),
    .nv_o   (nv),
    .sum_o  (sum)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_sweeps_q, m_conv_q, m_coord_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_rv_q;

endmodule

### src/gps_checker.sv
`timescale 1ns / 1ps

module gps_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [gps_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  input logic                               m_axis_tlast,
  input logic                               m_axis_tuser
);
  import gps_pkg::*;

  // A word that has not been taken stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // No new word is taken while a result waits on a stalled output.
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // The last-coordinate flag only comes with a stored coordinate.
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last flag without read data");

  // Results without read data carry no coordinate.
  a_empty_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[COORD_W-1:0] == '0)
    else $error("coordinate on a word without read data");

  // Read words carry no sweep status.
  a_read_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[TDATA_OUT_W-1:COORD_W] == '0)
    else $error("sweep status on a read word");

endmodule

bind gradient_path_smoother_top gps_checker u_gps_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// One reply that the block returns for a start or a read word.
typedef struct packed {
  logic [31:0] coord;
  logic        last;
  logic        conv;
  logic [15:0] sweeps;
  logic        valid;
} smooth_reply_t;

// Predicts the replies of the path smoother and checks the replies that arrive.
class path_smoothing_check;
  localparam longint SAT_HI  = 64'sh7FFF_FFFF;
  localparam longint SAT_LO  = -64'sh8000_0000;
  localparam longint SUM_TOP = 64'sh0000_FFFF_FFFF_FFFF;

  int unsigned n_dims, w_pull, w_smooth, stop_tol, sweep_cap;
  int orig_pts [gps_pkg::CAPACITY];
  int smooth_pts [gps_pkg::CAPACITY];
  int unsigned coord_count, rd_ptr;
  bit fresh_path;
  longint unsigned sweep_change;
  smooth_reply_t awaited_replies [$];
  int errors, loads_taken, runs_seen, runs_converged, reads_seen, reg_writes;

  function new();
    n_dims = 2;
    w_pull = 45875;
    w_smooth = 19661;
    stop_tol = 7;
    sweep_cap = 4096;
    coord_count = 0;
    rd_ptr = 0;
    fresh_path = 1'b1;
    sweep_change = 0;
    errors = 0;
    loads_taken = 0;
    runs_seen = 0;
    runs_converged = 0;
    reads_seen = 0;
    reg_writes = 0;
  endfunction

  function void apply_reg(logic [gps_pkg::CFG_IDX_W-1:0] idx, logic [30:0] val);
    reg_writes++;
    case (idx)
      gps_pkg::CFG_DIMS:          n_dims = val[2:0];
      gps_pkg::CFG_WEIGHT_DATA:   w_pull = val[16:0];
      gps_pkg::CFG_WEIGHT_SMOOTH: w_smooth = val[16:0];
      gps_pkg::CFG_TOLERANCE:     stop_tol = val;
      gps_pkg::CFG_MAX_SWEEPS:    sweep_cap = val[15:0];
      default: ;
    endcase
  endfunction

  // Dims of 0 behave as 1 and dims above the maximum behave as the maximum.
  function int unsigned eff_dims();
    if (n_dims == 0) return 1;
    if (n_dims > gps_pkg::MAX_DIMS) return gps_pkg::MAX_DIMS;
    return n_dims;
  endfunction

  // One in-place sweep over the interior points; neighbors before k are already new.
  function void relax_sweep(int unsigned npts, int unsigned d);
    int unsigned k;
    longint cur, prv, nxt, dif, lap, acc, nv;
    longint unsigned dlt;
    sweep_change = 0;
    for (int unsigned i = 1; i + 1 < npts; i++) begin
      for (int unsigned j = 0; j < d; j++) begin
        k = i * d + j;
        cur = smooth_pts[k];
        prv = smooth_pts[k - d];
        nxt = smooth_pts[k + d];
        dif = longint'(orig_pts[k]) - cur;
        lap = prv + nxt - 2 * cur;
        acc = longint'(w_pull) * dif + longint'(w_smooth) * lap + 32768;
        nv = cur + (acc >>> 16);
        if (nv > SAT_HI) nv = SAT_HI;
        if (nv < SAT_LO) nv = SAT_LO;
        dlt = (nv >= cur) ? longint'(nv - cur) : longint'(cur - nv);
        smooth_pts[k] = int'(nv);
        sweep_change += dlt;
        if (sweep_change > SUM_TOP) sweep_change = SUM_TOP;
      end
    end
  endfunction

  function smooth_reply_t smooth_path();
    smooth_reply_t r;
    int unsigned d, npts, sweeps;
    bit conv;
    d = eff_dims();
    npts = coord_count / d;
    sweeps = 0;
    conv = 1'b0;
    for (int unsigned k = 0; k < coord_count; k++) smooth_pts[k] = orig_pts[k];
    do begin
      relax_sweep(npts, d);
      sweeps++;
      conv = (sweep_change < stop_tol);
    end while (!conv && sweeps < sweep_cap);
    fresh_path = 1'b1;
    rd_ptr = 0;
    r = '0;
    r.conv = conv;
    r.sweeps = sweeps[15:0];
    runs_seen++;
    if (conv) runs_converged++;
    return r;
  endfunction

  function void note_word(logic [1:0] act, logic [31:0] raw);
    smooth_reply_t r;
    r = '0;
    case (act)
      gps_pkg::ACT_LOAD: begin
        if (fresh_path) begin
          coord_count = 0;
          fresh_path = 1'b0;
        end
        // Loads past the capacity of the store are dropped.
        if (coord_count < gps_pkg::CAPACITY) begin
          orig_pts[coord_count] = raw;
          smooth_pts[coord_count] = raw;
          coord_count++;
        end
        loads_taken++;
      end
      gps_pkg::ACT_START: awaited_replies.push_back(smooth_path());
      gps_pkg::ACT_READ: begin
        // Past the end the reply is all zeros and the pointer stays.
        if (rd_ptr < coord_count) begin
          r.coord = smooth_pts[rd_ptr];
          r.last = (rd_ptr + 1 == coord_count);
          r.valid = 1'b1;
          rd_ptr++;
        end
        reads_seen++;
        awaited_replies.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_reply(logic [gps_pkg::TDATA_OUT_W-1:0] tdata, logic tlast, logic tuser);
    smooth_reply_t r;
    if (awaited_replies.size() == 0) begin
      $display("%0t: unexpected reply, expected none, got tdata %h tlast %b tuser %b",
               $time, tdata, tlast, tuser);
      errors++;
      return;
    end
    r = awaited_replies.pop_front();
    compare_field("coord_out", r.coord, tdata[gps_pkg::COORD_W-1:0]);
    compare_field("converged", r.conv, tdata[gps_pkg::COORD_W]);
    compare_field("sweeps_used", r.sweeps, tdata[gps_pkg::COORD_W+1 +: gps_pkg::SWEEP_W]);
    compare_field("pad", 0, tdata[gps_pkg::TDATA_OUT_W-1:gps_pkg::OUT_BITS]);
    compare_field("last_coord", r.last, tlast);
    compare_field("read_valid", r.valid, tuser);
  endfunction
endclass

module testbench;
  import gps_pkg::*;

  // Action code that the block ignores; it yields no reply.
  localparam logic [ACTION_W-1:0] ACT_NOOP = 2'd3;
  // Cycles allowed after the last reply for a load word still in flight.
  localparam int DRAIN_CYCLES = 20;
  // Counted words of random stimulus per handshake mix.
  localparam int PHASE_WORDS = 175;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // coord_in
  logic [TUSER_IN_W-1:0]  s_axis_tuser = '0;   // action

  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;        // coord_out, converged, sweeps_used, zero pad
  logic                   m_axis_tlast;        // last_coord
  logic                   m_axis_tuser;        // read_valid

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  // Words handed to the block that it acts on (ignored codes are not counted).
  int words_sent = 0;

  path_smoothing_check sb;

  gradient_path_smoother_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The receiver checks every reply word taken at an edge, then picks its
  // ready for the next cycle. Values read here are those just before the edge.
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      sb.check_reply(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Sends one input word. Valid is lowered only inside an idle gap, so a
  // back-to-back word never sees valid dropped and raised in one time step.
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [31:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= val;
    s_axis_tuser <= act;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_word(act, val);
    if (act != ACT_NOOP) words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.apply_reg(idx, val);
  endtask

  // Writes all five registers in one burst; valid stays high across the burst.
  task automatic set_config(input logic [30:0] d, input logic [30:0] wd,
                            input logic [30:0] ws, input logic [30:0] tol,
                            input logic [30:0] ms);
    write_reg(CFG_DIMS, d);
    write_reg(CFG_WEIGHT_DATA, wd);
    write_reg(CFG_WEIGHT_SMOOTH, ws);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_SWEEPS, ms);
    cfg_valid_i <= 1'b0;
  endtask

  // Brings the block to idle: no input offered, every reply in, then a short
  // pause so that a trailing load word has surely been written.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly gentle values so that runs settle, with the rails and full-range
  // words mixed in to push the saturation and every data bit.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(11))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [30:0] pick_weight();
    case ($urandom_range(4))
      0: return 31'd0;
      1: return 31'd65536;
      default: return 31'($urandom_range(0, 65536));
    endcase
  endfunction

  // A random setting. The sweep cap stays low so that runs that never settle
  // stay short; dims outside 1..4 come up now and then.
  task automatic random_config();
    logic [30:0] d, tol, ms;
    d = ($urandom_range(3) == 0) ? 31'($urandom_range(7)) : 31'($urandom_range(1, 4));
    case ($urandom_range(5))
      0: tol = 31'd0;
      1: tol = 31'h7FFF_FFFF;
      default: tol = 31'($urandom_range(0, 4000));
    endcase
    ms = ($urandom_range(9) == 0) ? 31'd0 : 31'($urandom_range(1, 40));
    set_config(d, pick_weight(), pick_weight(), tol, ms);
  endtask

  // Most sequences are a whole job: load a path, start, read it all back.
  // The rest are loose words of any action, including reads before a start.
  task automatic random_sequence();
    int unsigned d, npts, ncoord, nread;
    d = sb.eff_dims();
    if ($urandom_range(99) < 78) begin
      npts = ($urandom_range(4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      ncoord = npts * d;
      // Sometimes leave a partial point at the tail.
      if (d > 1 && $urandom_range(3) == 0) ncoord += $urandom_range(1, d - 1);
      for (int unsigned k = 0; k < ncoord; k++) begin
        if ($urandom_range(29) == 0) send_word(ACT_NOOP, $urandom);
        send_word(ACT_LOAD, rand_coord());
      end
      if ($urandom_range(5) == 0) send_word(ACT_READ, $urandom);
      send_word(ACT_START, $urandom);
      nread = ncoord + $urandom_range(0, 2);
      // A short readout leaves the pointer part way for the next job.
      if ($urandom_range(7) == 0) nread = $urandom_range(0, ncoord);
      repeat (nread) send_word(ACT_READ, $urandom);
    end else begin
      repeat ($urandom_range(1, 6)) send_word(ACTION_W'($urandom_range(3)), rand_coord());
    end
  endtask

  initial begin
    int base;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset setting: a read and a start with no path,
    // the ignored code, a three-point path at the rails with a partial point,
    // reads before the start, then a full readout running one past the end.
    send_word(ACT_READ, 32'h0);
    send_word(ACT_NOOP, 32'hFFFF_FFFF);
    send_word(ACT_START, 32'h0);
    send_word(ACT_LOAD, 32'h7FFF_FFFF);
    send_word(ACT_LOAD, 32'h8000_0000);
    send_word(ACT_LOAD, 32'h8000_0000);
    send_word(ACT_LOAD, 32'h7FFF_FFFF);
    send_word(ACT_LOAD, 32'h0000_0000);
    send_word(ACT_LOAD, 32'hFFFF_FFFF);
    send_word(ACT_LOAD, 32'h1234_5678);
    send_word(ACT_READ, 32'h0);
    send_word(ACT_READ, 32'h0);
    send_word(ACT_START, 32'hFFFF_FFFF);
    repeat (8) send_word(ACT_READ, 32'h5555_AAAA);
    send_word(ACT_NOOP, 32'h0);

    // Four handshake mixes, each opening at an extreme setting and moving on
    // to random settings once the first third of its words has gone.
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          set_config(31'd1, 31'd65536, 31'd0, 31'd1, 31'd65535);
        end
        1: begin
          src_idle_pct = 83;
          sink_stall_pct = 0;
          set_config(31'd4, 31'd0, 31'd65536, 31'd0, 31'd5);
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 83;
          set_config(31'd0, 31'd0, 31'd0, 31'h7FFF_FFFF, 31'd0);
        end
        default: begin
          src_idle_pct = 18;
          sink_stall_pct = 18;
          set_config(31'd7, 31'd32768, 31'd32768, 31'd100, 31'd1);
        end
      endcase
      base = words_sent;
      while (words_sent - base < PHASE_WORDS) begin
        if (words_sent - base > PHASE_WORDS / 3 && $urandom_range(3) == 0) begin
          drain();
          random_config();
        end
        random_sequence();
      end
    end

    drain();
    $display("testbench: %0d loads, %0d smoothing runs (%0d converged, %0d hit the cap), %0d reads",
             sb.loads_taken, sb.runs_seen, sb.runs_converged,
             sb.runs_seen - sb.runs_converged, sb.reads_seen);
    $display("testbench: %0d register writes over four handshake mixes", sb.reg_writes);
    if (sb.errors == 0 && sb.awaited_replies.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #50_000_000;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
